### rtl/gls_pkg.sv
`timescale 1ns / 1ps

package gls_pkg;

    localparam int NUM_DEVICES  = 16;
    localparam int NUM_CHANNELS = NUM_DEVICES * 16;
    localparam int STORE_DEPTH  = NUM_CHANNELS;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);
    localparam int PAIR_W       = ADDR_W - 1;
    localparam int NUM_PAIRS    = NUM_CHANNELS / 2;

    localparam int OPC_W    = 3;
    localparam int CH_W     = 8;
    localparam int LVL_W    = 12;
    localparam int BYTE_W   = 8;
    localparam int PERIOD_W = 16;
    localparam int PART_W   = 2;

    localparam logic [PERIOD_W-1:0] BLANK_RESET = PERIOD_W'(255);

    // byte position within a channel pair
    localparam logic [PART_W-1:0] PART_HI  = PART_W'(0);
    localparam logic [PART_W-1:0] PART_MID = PART_W'(1);
    localparam logic [PART_W-1:0] PART_LO  = PART_W'(2);

    typedef enum logic [OPC_W-1:0] {
        OP_SET     = 3'd0,
        OP_SET_ALL = 3'd1,
        OP_START   = 3'd2,
        OP_SHIFT   = 3'd3,
        OP_GTICK   = 3'd4
    } t_opcode;

    typedef struct packed {
        logic [OPC_W-1:0] opcode;
        logic [CH_W-1:0]  channel;
        logic [LVL_W-1:0] level;
    } t_item;

    typedef struct packed {
        logic              byte_valid;
        logic [BYTE_W-1:0] serial_byte;
        logic              frame_end;
        logic              blank_pulse;
        logic              latch_pulse;
        logic              status;
    } t_result;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_FILL,
        S_READ_HI,
        S_READ_LO,
        S_EMIT,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
        logic sweep_wr;
        logic fill_zero;
        logic rd_hi;
        logic rd_lo;
        logic emit;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [OPC_W-1:0] opcode;
        logic             shifting;
        logic             sweep_last;
        logic             out_free;
    } t_dp_stat;

endpackage

### rtl/gls_ifs.sv
`timescale 1ns / 1ps

interface gls_item_if;
    logic          valid;
    logic          ready;
    gls_pkg::t_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gls_result_if;
    logic            valid;
    logic            ready;
    gls_pkg::t_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gls_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [gls_pkg::PERIOD_W-1:0]   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/grayscale_led_frame_shifter.sv
// Channel    Dir  Payload                                            Transfer
// i_item     in   opcode[2:0], channel[7:0], level[11:0]             valid & ready
// o_result   out  byte_valid, serial_byte[7:0], frame_end,           valid & ready
//                 blank_pulse, latch_pulse, status
// i_cfg      in   blank_period[15:0]                                 valid & ready
//
// Set channel, start update, grayscale tick, idle shift: decode, then finish, which waits for a free output register.
// Shift tick while shifting: decode, two reads through the store's one read port, emit, finish.
// Set all: decode, a fill pass writing the level to every store entry, one store write per cycle, then finish.
// After reset a clearing pass zeroes the store; i_item.ready stays low. Items are taken one at a time.
// A finished result waits in the output register; the next item is still taken.
`timescale 1ns / 1ps

module grayscale_led_frame_shifter (
    input logic          i_clk,
    input logic          i_rst_n,
    gls_item_if.sink     i_item,
    gls_result_if.source o_result,
    gls_cfg_if.sink      i_cfg
);
    import gls_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     item_ready;

    gls_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (i_item.valid),
        .o_item_ready (item_ready),
        .o_cmd        (cmd),
        .i_stat       (stat)
    );

    gls_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_item      (i_item.data),
        .o_res_valid (o_result.valid),
        .o_res       (o_result.data),
        .i_res_ready (o_result.ready),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_data  (i_cfg.data)
    );

    assign i_item.ready = item_ready;
    assign i_cfg.ready  = 1'b1;

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> !i_item.ready)
        else $error("item accepted while previous one in progress");

    a_no_accept_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_item.ready)
        else $error("item port ready during clearing pass");

    a_latch_with_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.data.latch_pulse) |-> o_result.data.blank_pulse)
        else $error("latch pulse without blank pulse");

    a_frame_end_on_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.data.frame_end) |-> o_result.data.byte_valid)
        else $error("frame end without a frame byte");

    a_busy_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.data.status)
            |-> !(o_result.data.byte_valid || o_result.data.blank_pulse))
        else $error("busy status mixed with other result fields");

endmodule

### rtl/gls_ram.sv
`timescale 1ns / 1ps

module gls_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/gls_datapath.sv
`timescale 1ns / 1ps

module gls_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  gls_pkg::t_dp_cmd               i_cmd,
    output gls_pkg::t_dp_stat              o_stat,
    input  gls_pkg::t_item                 i_item,
    output logic                           o_res_valid,
    output gls_pkg::t_result               o_res,
    input  logic                           i_res_ready,
    input  logic                           i_cfg_valid,
    input  logic [gls_pkg::PERIOD_W-1:0]   i_cfg_data
);
    import gls_pkg::*;

    t_item               r_item;
    logic [PERIOD_W-1:0] r_period;
    logic [PERIOD_W-1:0] r_count,    n_count;
    logic                r_shifting, n_shifting;
    logic                r_latch,    n_latch;
    logic [PAIR_W-1:0]   r_pair,     n_pair;
    logic [PART_W-1:0]   r_part,     n_part;
    logic [ADDR_W-1:0]   r_sweep,    n_sweep;
    logic [LVL_W-1:0]    r_hi;
    t_result             r_res,      n_res;
    t_result             r_out;
    logic                r_out_valid;

    logic [PERIOD_W:0]   count_inc;
    logic                set_hit;
    logic                out_free;
    logic [ADDR_W-1:0]   hi_ch;
    logic [ADDR_W-1:0]   lo_ch;
    logic                ram_wr_en;
    logic [ADDR_W-1:0]   ram_wr_addr;
    logic [LVL_W-1:0]    ram_wr_data;
    logic                ram_rd_en;
    logic [ADDR_W-1:0]   ram_rd_addr;
    logic [LVL_W-1:0]    ram_rd_data;

    assign count_inc = {1'b0, r_count} + (PERIOD_W+1)'(1);
    assign set_hit   = {1'b0, r_item.channel} < (CH_W+1)'(NUM_CHANNELS);
    assign out_free  = !r_out_valid || i_res_ready;

    assign hi_ch = ADDR_W'(NUM_CHANNELS - 1) - {r_pair, 1'b0};
    assign lo_ch = {hi_ch[ADDR_W-1:1], 1'b0};

    assign ram_wr_en   = i_cmd.sweep_wr
                       || (i_cmd.exec && r_item.opcode == OP_SET && set_hit);
    assign ram_wr_addr = i_cmd.sweep_wr ? r_sweep : r_item.channel[ADDR_W-1:0];
    assign ram_wr_data = i_cmd.fill_zero ? '0 : r_item.level;
    assign ram_rd_en   = i_cmd.rd_hi || i_cmd.rd_lo;
    assign ram_rd_addr = i_cmd.rd_hi ? hi_ch : lo_ch;

    gls_ram #(
        .WIDTH (LVL_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    always_comb begin
        n_count    = r_count;
        n_shifting = r_shifting;
        n_latch    = r_latch;
        n_pair     = r_pair;
        n_part     = r_part;
        n_sweep    = r_sweep;
        n_res      = r_res;

        if (i_cmd.sweep_wr) begin
            n_sweep = r_sweep + ADDR_W'(1);
        end

        if (i_cmd.exec) begin
            n_res = '0;
            case (r_item.opcode)
                OP_START: begin
                    if (r_shifting || r_latch) begin
                        n_res.status = 1'b1;
                    end else begin
                        n_shifting = 1'b1;
                        n_pair     = '0;
                        n_part     = PART_HI;
                    end
                end
                OP_GTICK: begin
                    if (count_inc >= {1'b0, r_period}) begin
                        n_res.blank_pulse = 1'b1;
                        n_res.latch_pulse = r_latch;
                        n_latch           = 1'b0;
                        n_count           = '0;
                    end else begin
                        n_count = count_inc[PERIOD_W-1:0];
                    end
                end
                default: ;
            endcase
        end

        if (i_cmd.emit) begin
            n_res            = '0;
            n_res.byte_valid = 1'b1;
            case (r_part)
                PART_HI:  n_res.serial_byte = r_hi[LVL_W-1:LVL_W-BYTE_W];
                PART_MID: n_res.serial_byte = {r_hi[LVL_W-BYTE_W-1:0],
                                               ram_rd_data[LVL_W-1:BYTE_W]};
                default:  n_res.serial_byte = ram_rd_data[BYTE_W-1:0];
            endcase
            if (r_part == PART_LO) begin
                n_part = PART_HI;
                if (r_pair == PAIR_W'(NUM_PAIRS - 1)) begin
                    n_res.frame_end = 1'b1;
                    n_shifting      = 1'b0;
                    n_pair          = '0;
                    n_latch         = 1'b1;
                end else begin
                    n_pair = r_pair + PAIR_W'(1);
                end
            end else begin
                n_part = r_part + PART_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period    <= BLANK_RESET;
            r_count     <= '0;
            r_shifting  <= 1'b0;
            r_latch     <= 1'b0;
            r_pair      <= '0;
            r_part      <= PART_HI;
            r_sweep     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_period <= i_cfg_data;
            end
            r_count    <= n_count;
            r_shifting <= n_shifting;
            r_latch    <= n_latch;
            r_pair     <= n_pair;
            r_part     <= n_part;
            r_sweep    <= n_sweep;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.rd_lo) begin
            r_hi <= ram_rd_data;
        end
        r_res <= n_res;
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    assign o_stat.opcode     = r_item.opcode;
    assign o_stat.shifting   = r_shifting;
    assign o_stat.sweep_last = r_sweep == ADDR_W'(STORE_DEPTH - 1);
    assign o_stat.out_free   = out_free;

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

### rtl/gls_ctrl.sv
`timescale 1ns / 1ps

module gls_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_item_valid,
    output logic              o_item_ready,
    output gls_pkg::t_dp_cmd  o_cmd,
    input  gls_pkg::t_dp_stat i_stat
);
    import gls_pkg::*;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_stat.sweep_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_item_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                case (i_stat.opcode)
                    OP_SET_ALL: n_state = S_FILL;
                    OP_SHIFT:   n_state = i_stat.shifting ? S_READ_HI : S_FINISH;
                    default:    n_state = S_FINISH;
                endcase
            end
            S_FILL: begin
                if (i_stat.sweep_last) n_state = S_FINISH;
            end
            S_READ_HI: n_state = S_READ_LO;
            S_READ_LO: n_state = S_EMIT;
            S_EMIT:    n_state = S_FINISH;
            S_FINISH: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_item_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.sweep_wr  = 1'b1;
                o_cmd.fill_zero = 1'b1;
            end
            S_IDLE: begin
                o_item_ready = 1'b1;
                o_cmd.load   = i_item_valid;
            end
            S_DECODE:  o_cmd.exec     = 1'b1;
            S_FILL:    o_cmd.sweep_wr = 1'b1;
            S_READ_HI: o_cmd.rd_hi    = 1'b1;
            S_READ_LO: o_cmd.rd_lo    = 1'b1;
            S_EMIT:    o_cmd.emit     = 1'b1;
            S_FINISH:  o_cmd.out_load = i_stat.out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
